FILE: rtl/fba_pkg.sv
// Shared types, constants and codes of the fit-policy block allocator.
package fba_pkg;

   localparam int MAX_BLOCKS  = 128;
   localparam int SIZE_BITS   = 16;
   localparam int ADDR_BITS   = $clog2(MAX_BLOCKS);
   localparam int CNT_BITS    = $clog2(MAX_BLOCKS + 1);
   localparam int OP_BITS     = 2;
   localparam int SLOT_BITS   = 7;
   localparam int CHOSEN_BITS = 7;
   localparam int MODE_BITS   = 2;
   localparam int COUNT_BITS  = 8;
   localparam int CSR_IDX_BITS  = 8;
   localparam int CSR_DATA_BITS = 8;

   // Request word payload widths, padded to whole bytes.
   localparam int REQ_FIELD_BITS = SLOT_BITS + 2 * SIZE_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((CHOSEN_BITS + 7) / 8) * 8;

   // Each table entry holds the remaining size above the original size.
   localparam int ENTRY_BITS = 2 * SIZE_BITS;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FIT_MODE    = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCK_COUNT = CSR_IDX_BITS'(1);

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD    = 2'd0,
      OP_NEW_RUN = 2'd1,
      OP_PLACE   = 2'd2
   } op_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_FIRST = 2'd0,
      MODE_BEST  = 2'd1,
      MODE_WORST = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [SLOT_BITS-1:0] slot;
      logic [SIZE_BITS-1:0] block_size;
      logic [SIZE_BITS-1:0] request_size;
   } req_item_type;

   typedef struct packed {
      logic                   placed;
      logic [CHOSEN_BITS-1:0] chosen_block;
   } rsp_item_type;

   typedef struct packed {
      logic                 clear_all;
      logic                 set_dirty;
      logic                 set_occ;
      logic [ADDR_BITS-1:0] set_idx;
   } marks_ctl_type;

endpackage

FILE: rtl/fba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/fba_marks.sv
// Per-entry occupied marks and remaining-size dirty bits, cleared together by a new run.
module fba_marks (
   input  logic                           clock,
   input  logic                           reset,
   input  fba_pkg::marks_ctl_type         ctl,
   input  logic [fba_pkg::ADDR_BITS-1:0]  rd_idx,
   output logic                           dirty_bit,
   output logic                           occ_bit
);
   import fba_pkg::*;

   logic [MAX_BLOCKS-1:0] dirty_ff, dirty_in;
   logic [MAX_BLOCKS-1:0] occ_ff, occ_in;

   // A clean entry has never been consumed in this run, so its remaining
   // size equals its original size regardless of what the table holds.
   always_comb begin
      dirty_in = dirty_ff;
      occ_in   = occ_ff;
      if (ctl.clear_all) begin
         dirty_in = '0;
         occ_in   = '0;
      end else begin
         if (ctl.set_dirty) begin
            dirty_in[ctl.set_idx] = 1'b1;
         end
         if (ctl.set_occ) begin
            occ_in[ctl.set_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= '0;
         occ_ff   <= '0;
      end else begin
         dirty_ff <= dirty_in;
         occ_ff   <= occ_in;
      end
   end

   assign dirty_bit = dirty_ff[rd_idx];
   assign occ_bit   = occ_ff[rd_idx];

endmodule

FILE: rtl/fba_engine.sv
// Scan engine: table memory, marks and the sequencer that places one request at a time.
module fba_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fba_pkg::MODE_BITS-1:0]   fit_mode,
   input  logic [fba_pkg::COUNT_BITS-1:0]  block_count,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  fba_pkg::req_item_type           req_item,
   output logic                            res_valid,
   input  logic                            res_ready,
   output fba_pkg::rsp_item_type           res_item
);
   import fba_pkg::*;

   state_type state_ff, state_in;

   logic [SIZE_BITS-1:0] want_ff, want_in;
   logic [CNT_BITS-1:0]  iss_ff, iss_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [ADDR_BITS-1:0] cmp_idx_ff, cmp_idx_in;
   logic                 found_ff, found_in;
   logic [ADDR_BITS-1:0] pick_ff, pick_in;
   logic [SIZE_BITS-1:0] pick_sz_ff, pick_sz_in;
   logic [SIZE_BITS-1:0] new_rem_ff, new_rem_in;

   logic [CNT_BITS-1:0]   limit;
   logic                  mode_ok;
   logic                  is_first;
   logic                  slot_ok;
   logic                  rd_en;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [ENTRY_BITS-1:0] rd_data;
   logic [SIZE_BITS-1:0]  orig_sz;
   logic [SIZE_BITS-1:0]  eff_rem;
   logic                  dirty_bit;
   logic                  occ_bit;
   logic                  hit_first;
   logic                  cand;
   logic                  better;
   logic                  last_cmp;
   logic                  finish;
   marks_ctl_type         marks_ctl;

   assign limit = (int'(block_count) > MAX_BLOCKS) ? CNT_BITS'(MAX_BLOCKS)
                                                   : CNT_BITS'(block_count);
   assign mode_ok  = (fit_mode == MODE_FIRST) || (fit_mode == MODE_BEST) ||
                     (fit_mode == MODE_WORST);
   assign is_first = (fit_mode == MODE_FIRST);
   assign slot_ok  = int'(req_item.slot) < MAX_BLOCKS;

   fba_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   fba_marks u_marks (
      .clock     (clock),
      .reset     (reset),
      .ctl       (marks_ctl),
      .rd_idx    (cmp_idx_ff),
      .dirty_bit (dirty_bit),
      .occ_bit   (occ_bit)
   );

   // Compare stage on the entry whose read data has just returned.
   assign orig_sz   = rd_data[SIZE_BITS-1:0];
   assign eff_rem   = dirty_bit ? rd_data[ENTRY_BITS-1:SIZE_BITS] : orig_sz;
   assign hit_first = eff_rem >= want_ff;
   assign cand      = !occ_bit && (orig_sz >= want_ff);
   assign better    = !found_ff ||
                      ((fit_mode == MODE_BEST)  && (orig_sz < pick_sz_ff)) ||
                      ((fit_mode == MODE_WORST) && (orig_sz > pick_sz_ff));
   assign last_cmp  = (CNT_BITS'(cmp_idx_ff) + CNT_BITS'(1)) == limit;
   assign finish    = (state_ff == ST_DONE) && res_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_item.op == OP_PLACE)) begin
               if ((limit == '0) || !mode_ok) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cmp_vld_ff && ((is_first && hit_first) || last_cmp)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs toward the table, the marks and the handshakes.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      res_valid = (state_ff == ST_DONE);
      rd_en     = (state_ff == ST_SCAN) && (iss_ff < limit);
      wr_en     = 1'b0;
      wr_addr   = pick_ff;
      wr_data   = {new_rem_ff, pick_sz_ff};
      marks_ctl = '{clear_all: 1'b0, set_dirty: 1'b0, set_occ: 1'b0, set_idx: pick_ff};
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_item.op)
                  OP_LOAD: begin
                     wr_en   = slot_ok;
                     wr_addr = ADDR_BITS'(req_item.slot);
                     wr_data = {req_item.block_size, req_item.block_size};
                  end
                  OP_NEW_RUN: marks_ctl.clear_all = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_DONE: begin
            if (finish && found_ff) begin
               wr_en               = is_first;
               marks_ctl.set_dirty = is_first;
               marks_ctl.set_occ   = !is_first;
            end
         end
         default: ;
      endcase
   end

   // Scan datapath.
   always_comb begin
      want_in    = want_ff;
      iss_in     = iss_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      found_in   = found_ff;
      pick_in    = pick_ff;
      pick_sz_in = pick_sz_ff;
      new_rem_in = new_rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_item.op == OP_PLACE)) begin
               want_in  = req_item.request_size;
               iss_in   = '0;
               found_in = 1'b0;
               pick_in  = '0;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               iss_in     = iss_ff + CNT_BITS'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = iss_ff[ADDR_BITS-1:0];
            end
            if (cmp_vld_ff) begin
               if (is_first) begin
                  if (hit_first) begin
                     found_in   = 1'b1;
                     pick_in    = cmp_idx_ff;
                     pick_sz_in = orig_sz;
                     new_rem_in = eff_rem - want_ff;
                  end
               end else if (cand && better) begin
                  found_in   = 1'b1;
                  pick_in    = cmp_idx_ff;
                  pick_sz_in = orig_sz;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff    <= want_in;
      iss_ff     <= iss_in;
      cmp_idx_ff <= cmp_idx_in;
      pick_ff    <= pick_in;
      pick_sz_ff <= pick_sz_in;
      new_rem_ff <= new_rem_in;
   end

   assign res_item.placed       = found_ff;
   assign res_item.chosen_block = found_ff ? CHOSEN_BITS'(pick_ff) : '0;

endmodule

FILE: rtl/fit_policy_block_allocator_core.sv
// Top level of the fit-policy block allocator: ports, control registers and result register.
//
//   Channel  Direction  Handshake               Carries
//   req_     in         req_tvalid/req_tready   one command word (load, new run, place)
//   rsp_     out        rsp_tvalid/rsp_tready   one result word per place command
//   csr_     in         csr_valid/csr_ready     one control register write
//
// A place word scans up to N table entries, where N is the number of blocks in use
// (at most 128): the block table is a single memory with a registered read, scanned
// one entry per cycle, and first fit stops at the first block that fits. There is no
// clearing pass after reset; per-entry dirty and occupied bits in flip-flops clear at
// once on reset and on a new run. The result register lets the next command word be
// taken while a result still waits; the engine only holds when a new result meets a
// full register.
module fit_policy_block_allocator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // Command words.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata, from bit 0 up: block_slot, block_size, request_size, zero padding.
   input  logic [fba_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // tuser: op.
   input  logic [fba_pkg::OP_BITS-1:0]          req_tuser,
   // Result words.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata, from bit 0 up: chosen_block, zero padding.
   output logic [fba_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // tuser: placed.
   output logic                                 rsp_tuser,
   // Control register writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fba_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [fba_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import fba_pkg::*;

   logic [MODE_BITS-1:0]   fit_mode_ff, fit_mode_in;
   logic [COUNT_BITS-1:0]  block_count_ff, block_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;

   req_item_type           req_item;
   rsp_item_type           res_item;
   logic                   res_valid;
   logic                   res_ready;

   // Unpack the command word into its fields.
   assign req_item.op           = req_tuser;
   assign req_item.slot         = req_tdata[SLOT_BITS-1:0];
   assign req_item.block_size   = req_tdata[SLOT_BITS +: SIZE_BITS];
   assign req_item.request_size = req_tdata[SLOT_BITS + SIZE_BITS +: SIZE_BITS];

   // Register writes are always taken; an unknown index is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      fit_mode_in    = fit_mode_ff;
      block_count_in = block_count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FIT_MODE:    fit_mode_in    = csr_data[MODE_BITS-1:0];
            CSR_BLOCK_COUNT: block_count_in = csr_data[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   fba_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fit_mode    (fit_mode_ff),
      .block_count (block_count_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_item    (req_item),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_item    (res_item)
   );

   // The result register is free when empty or when its word leaves this cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_item_in = res_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= '0;
         block_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fit_mode_ff    <= fit_mode_in;
         block_count_ff <= block_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.placed;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_item_ff.chosen_block);

endmodule
